### hw/rtl/dlr_pkg.sv
package dlr_pkg;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    localparam int COLOR_BITS = 4;

endpackage

### hw/rtl/dlr_front.sv
module dlr_front
#(
    parameter int COORD_BITS = 10,
    parameter int IN_W       = 48,
    parameter type cmd_t     = logic
)
(
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,
    input  dlr_pkg::op_t      s_axis_tuser,
    output logic              push,
    output cmd_t              push_cmd,
    input  logic              full
);
    import dlr_pkg::*;

    localparam int C = COORD_BITS;

    logic [C-1:0]          x0;
    logic [C-1:0]          y0;
    logic [C-1:0]          x1;
    logic [C-1:0]          y1;
    logic [C-1:0]          ax;
    logic [C-1:0]          ay;
    logic                  sx;
    logic                  sy;
    logic [COLOR_BITS-1:0] color;

    assign x0    = s_axis_tdata[C-1:0];
    assign y0    = s_axis_tdata[2*C-1:C];
    assign x1    = s_axis_tdata[3*C-1:2*C];
    assign y1    = s_axis_tdata[4*C-1:3*C];
    assign color = s_axis_tdata[4*C+COLOR_BITS-1:4*C];

    // direction and magnitude per axis
    assign sx = x1 < x0;
    assign sy = y1 < y0;
    assign ax = sx ? (x0 - x1) : (x1 - x0);
    assign ay = sy ? (y0 - y1) : (y1 - y0);

    assign s_axis_tready = !full;
    assign push          = s_axis_tvalid && !full;

    always_comb
    begin
        push_cmd       = '0;
        push_cmd.op    = s_axis_tuser;
        push_cmd.x0    = x0;
        push_cmd.y0    = y0;
        push_cmd.ax    = ax;
        push_cmd.ay    = ay;
        push_cmd.sx    = sx;
        push_cmd.sy    = sy;
        push_cmd.steps = (ax > ay) ? ax : ay;
        push_cmd.color = color;
    end

endmodule

### hw/rtl/dlr_fifo.sv
module dlr_fifo
#(
    parameter int  DEPTH = 4,
    parameter type cmd_t = logic
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg != CNT_W'(DEPTH)))
        else $error("request queue overflow");

endmodule

### hw/rtl/dlr_div.sv
module dlr_div
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] dividend_mag,
    input  logic [COORD_BITS-1:0] divisor,
    output logic                  done,
    output logic [FRAC_BITS:0]    quot
);
    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int NW    = C + F + 1;
    localparam int CNT_W = $clog2(F + 2);

    typedef enum logic
    {
        DV_IDLE,
        DV_RUN
    } dv_state_t;

    dv_state_t        state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [C-1:0]     rem_reg;
    logic [F:0]       nq_reg;
    logic [C-1:0]     den_reg;
    logic             done_reg;

    logic [NW-1:0]    numer;
    logic [C:0]       shifted;
    logic [C:0]       diff;
    logic             ge;

    // (mag << F) + divisor/2 gives the rounded quotient; it is below divisor << (F+1),
    // so the top C bits start as a valid partial remainder
    assign numer   = {1'b0, dividend_mag, {F{1'b0}}} + NW'(divisor >> 1);
    assign shifted = {rem_reg, nq_reg[F]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    assign done = done_reg;
    assign quot = nq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            nq_reg    <= '0;
            den_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= numer[NW-1:F+1];
                        nq_reg    <= numer[F:0];
                        den_reg   <= divisor;
                        cnt_reg   <= CNT_W'(F + 1);
                        state_reg <= DV_RUN;
                    end
                end
                DV_RUN:
                begin
                    rem_reg <= ge ? diff[C-1:0] : shifted[C-1:0];
                    nq_reg  <= {nq_reg[F-1:0], ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= DV_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/dlr_back.sv
module dlr_back
#(
    parameter int  COORD_BITS = 10,
    parameter int  FRAC_BITS  = 16,
    parameter int  OUT_W      = 24,
    parameter type cmd_t      = logic
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_t             cmd,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast
);
    import dlr_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int ACC_W = C + F + 2;
    localparam int PL_W  = C + 1;
    localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << (F - 1);

    typedef enum logic
    {
        ST_RUN,
        ST_DIV
    } state_t;

    state_t                   state_reg;
    logic signed [ACC_W-1:0]  x_acc_reg;
    logic signed [ACC_W-1:0]  y_acc_reg;
    logic signed [ACC_W-1:0]  x_step_reg;
    logic signed [ACC_W-1:0]  y_step_reg;
    logic [PL_W-1:0]          pixels_left_reg;
    logic [COLOR_BITS-1:0]    color_reg;
    logic                     sx_reg;
    logic                     sy_reg;
    logic                     out_valid_reg;
    logic [C-1:0]             out_x_reg;
    logic [C-1:0]             out_y_reg;
    logic [COLOR_BITS-1:0]    out_color_reg;
    logic                     out_last_reg;

    logic                     is_step;
    logic                     out_free;
    logic                     emit;
    logic                     load;
    logic                     div_start;
    logic                     div_done_x;
    logic                     div_done_y;
    logic [F:0]               q_x;
    logic [F:0]               q_y;
    logic signed [ACC_W-1:0]  qx_ext;
    logic signed [ACC_W-1:0]  qy_ext;

    function automatic logic [C-1:0] round_coord(logic signed [ACC_W-1:0] acc);
        logic [ACC_W:0] v;
        v = {acc[ACC_W-1], acc} + HALF;
        if (v[ACC_W])
        begin
            return '0;
        end
        else if (|v[ACC_W-1:F+C])
        begin
            return '1;
        end
        return v[F+C-1:F];
    endfunction

    assign is_step   = cmd.op == OP_STEP;
    assign out_free  = !out_valid_reg || m_axis_tready;
    // a step on a finished line is dropped; a load never waits on the output
    assign cmd_ready = (state_reg == ST_RUN)
                       && (!is_step || pixels_left_reg == '0 || out_free);
    assign emit      = cmd_valid && cmd_ready && is_step && pixels_left_reg != '0;
    assign load      = cmd_valid && cmd_ready && !is_step;
    assign div_start = load && cmd.steps != '0;

    assign qx_ext = {{(ACC_W-F-1){1'b0}}, q_x};
    assign qy_ext = {{(ACC_W-F-1){1'b0}}, q_y};

    dlr_div #(.COORD_BITS(C), .FRAC_BITS(F)) u_div_x
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .dividend_mag (cmd.ax),
        .divisor      (cmd.steps),
        .done         (div_done_x),
        .quot         (q_x)
    );

    dlr_div #(.COORD_BITS(C), .FRAC_BITS(F)) u_div_y
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .dividend_mag (cmd.ay),
        .divisor      (cmd.steps),
        .done         (div_done_y),
        .quot         (q_y)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = OUT_W'({out_color_reg, out_y_reg, out_x_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RUN;
            x_acc_reg       <= '0;
            y_acc_reg       <= '0;
            x_step_reg      <= '0;
            y_step_reg      <= '0;
            pixels_left_reg <= '0;
            color_reg       <= '0;
            sx_reg          <= 1'b0;
            sy_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            out_color_reg   <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_RUN:
                begin
                    if (load)
                    begin
                        x_acc_reg       <= {2'b00, cmd.x0, {F{1'b0}}};
                        y_acc_reg       <= {2'b00, cmd.y0, {F{1'b0}}};
                        pixels_left_reg <= {1'b0, cmd.steps} + 1'b1;
                        color_reg       <= cmd.color;
                        sx_reg          <= cmd.sx;
                        sy_reg          <= cmd.sy;
                        x_step_reg      <= '0;
                        y_step_reg      <= '0;
                        if (cmd.steps != '0)
                        begin
                            state_reg <= ST_DIV;
                        end
                    end
                    else if (emit)
                    begin
                        out_x_reg       <= round_coord(x_acc_reg);
                        out_y_reg       <= round_coord(y_acc_reg);
                        out_color_reg   <= color_reg;
                        out_last_reg    <= pixels_left_reg == PL_W'(1);
                        pixels_left_reg <= pixels_left_reg - 1'b1;
                        x_acc_reg       <= x_acc_reg + x_step_reg;
                        y_acc_reg       <= y_acc_reg + y_step_reg;
                    end
                end
                ST_DIV:
                begin
                    if (div_done_x)
                    begin
                        x_step_reg <= sx_reg ? -qx_ext : qx_ext;
                        y_step_reg <= sy_reg ? -qy_ext : qy_ext;
                        state_reg  <= ST_RUN;
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_done_x == div_done_y)
        else $error("dividers out of step");

    a_emit_live: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (state_reg == ST_RUN && pixels_left_reg != '0 && out_free))
        else $error("pixel emitted without a live line");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && pixels_left_reg == PL_W'(1)) |=> (pixels_left_reg == '0 && m_axis_tlast))
        else $error("last pixel did not close the line");

endmodule

### hw/rtl/dda_line_rasterizer_unit.sv
// channel     | group            | payload (low bit first)
// ------------+------------------+-----------------------------------------------
// request in  | s_axis_t*        | tdata: start_x, start_y, end_x, end_y, colour
//             |                  | tuser: operation (0 load, 1 step)
// pixel out   | m_axis_t*        | tdata: pixel_x, pixel_y, colour; tlast: last
//
// A step request passes the request queue, then its pixel is registered for output; one pixel
// a cycle while no divide runs and the output does not stall. A load with distinct endpoints
// holds the back end for set-up, FRAC_BITS+1 quotient bits from the restoring dividers and
// capture; steps queue behind it. Up to QUEUE_DEPTH requests queue while the back end divides
// or the pixel output stalls. Reset clears all control state; no clearing pass is needed.
module dda_line_rasterizer_unit
#(
    parameter int COORD_BITS  = 10,
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4,
    localparam int IN_W  = ((4 * COORD_BITS + dlr_pkg::COLOR_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + dlr_pkg::COLOR_BITS + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // start_x, start_y, end_x, end_y, pixel_color
    input  dlr_pkg::op_t     s_axis_tuser,   // operation
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // pixel_x, pixel_y, color_out
    output logic             m_axis_tlast    // last_pixel
);
    import dlr_pkg::*;

    typedef struct packed
    {
        op_t                   op;
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] ax;
        logic [COORD_BITS-1:0] ay;
        logic                  sx;
        logic                  sy;
        logic [COORD_BITS-1:0] steps;
        logic [COLOR_BITS-1:0] color;
    } cmd_t;

    logic push;
    logic full;
    logic pop;
    logic empty;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    dlr_front #(.COORD_BITS(COORD_BITS), .IN_W(IN_W), .cmd_t(cmd_t)) u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_cmd      (push_cmd),
        .full          (full)
    );

    dlr_fifo #(.DEPTH(QUEUE_DEPTH), .cmd_t(cmd_t)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    logic cmd_ready;

    assign pop = !empty && cmd_ready;

    dlr_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .OUT_W(OUT_W),
               .cmd_t(cmd_t)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (!empty),
        .cmd_ready     (cmd_ready),
        .cmd           (pop_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dlr_pkg::*;

    localparam int COORD_BITS  = 10;
    localparam int FRAC_BITS   = 16;
    localparam int ACC_W       = FRAC_BITS + COORD_BITS + 2;
    localparam int IN_W        = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
    localparam int OUT_W       = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int WORK_TARGET = 1600;
    localparam int SETTLE      = 120;     // time for a full queue of loads to pass the dividers, with margin
    localparam int HANG_LIMIT  = 2000;

    typedef struct packed
    {
        op_t                   op;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        logic [COLOR_BITS-1:0] color;
    } request_t;

    typedef struct packed
    {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pixel_t;

    typedef enum logic [1:0]
    {
        BY_MODEL,
        NO_PIXEL,
        FIXED_PIXEL
    } verdict_t;

    typedef struct packed
    {
        request_t req;
        verdict_t verdict;
        pixel_t   want;
    } row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;    // start_x, start_y, end_x, end_y, pixel_color
    op_t              s_axis_tuser = OP_LOAD; // operation
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;         // pixel_x, pixel_y, color_out
    logic             m_axis_tlast;         // last_pixel

    dda_line_rasterizer_unit u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    // line tracer state
    logic signed [ACC_W-1:0] trace_x, trace_y, inc_x, inc_y;
    logic [COORD_BITS:0]     pixels_to_go;
    logic [COLOR_BITS-1:0]   trace_color;

    pixel_t pixel_q [$];
    bit     quiet;
    int     errors, work_items, hold_left, hang_cycles;
    int     n_lines, n_replaced, n_idle_steps, n_checked, n_longest;

    function automatic logic signed [ACC_W-1:0] axis_increment(input int d, input int steps);
        longint mag, q;
        if (steps == 0)
            return '0;
        mag = longint'(d < 0 ? -d : d);
        q = ((mag << FRAC_BITS) + longint'(steps / 2)) / longint'(steps);   // ties go up
        return d < 0 ? ACC_W'(-q) : ACC_W'(q);
    endfunction

    // floor(acc + 0.5), clamped to the screen
    function automatic logic [COORD_BITS-1:0] snap(input logic signed [ACC_W-1:0] acc);
        longint v;
        v = longint'(acc);
        v = (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_BITS'(COORD_MAX);
        return COORD_BITS'(v);
    endfunction

    function automatic bit rasterize(input request_t r, output pixel_t px);
        int dx, dy, ax, ay, steps;
        px = '0;
        if (r.op == OP_LOAD)
        begin
            if (pixels_to_go != 0)
                n_replaced++;
            dx = int'(r.ex) - int'(r.sx);
            dy = int'(r.ey) - int'(r.sy);
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            steps = ax > ay ? ax : ay;
            trace_x = {2'b00, r.sx, {FRAC_BITS{1'b0}}};
            trace_y = {2'b00, r.sy, {FRAC_BITS{1'b0}}};
            inc_x = axis_increment(dx, steps);
            inc_y = axis_increment(dy, steps);
            pixels_to_go = (COORD_BITS + 1)'(steps + 1);
            trace_color = r.color;
            n_lines++;
            if (steps + 1 > n_longest)
                n_longest = steps + 1;
            return 1'b0;
        end
        if (pixels_to_go == 0)
        begin
            n_idle_steps++;
            return 1'b0;
        end
        px.x = snap(trace_x);
        px.y = snap(trace_y);
        px.color = trace_color;
        px.last = pixels_to_go == 1;
        pixels_to_go--;
        trace_x += inc_x;
        trace_y += inc_y;
        return 1'b1;
    endfunction

    // mostly back to back, now and then a long pause
    function automatic int pause_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic request_t any_request(input op_t op);
        request_t r;
        r.op = op;
        r.sx = COORD_BITS'($urandom_range(0, COORD_MAX));
        r.sy = COORD_BITS'($urandom_range(0, COORD_MAX));
        r.ex = COORD_BITS'($urandom_range(0, COORD_MAX));
        r.ey = COORD_BITS'($urandom_range(0, COORD_MAX));
        r.color = COLOR_BITS'($urandom_range(0, (1 << COLOR_BITS) - 1));
        return r;
    endfunction

    function automatic logic [COORD_BITS-1:0] near(input logic [COORD_BITS-1:0] c, input int span);
        int v;
        if (span >= COORD_MAX)
            return COORD_BITS'($urandom_range(0, COORD_MAX));
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_BITS'(COORD_MAX);
        return COORD_BITS'(v);
    endfunction

    // called at a rising edge; returns at the edge where the request is taken
    task automatic issue(input request_t r);
        int gap;
        gap = pause_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_W - 4 * COORD_BITS - COLOR_BITS){1'b0}},
                         r.color, r.ey, r.ex, r.sy, r.sx};
        s_axis_tuser <= r.op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic run(input request_t r);
        pixel_t px;
        issue(r);
        if (rasterize(r, px))
        begin
            pixel_q.push_back(px);
            work_items++;
        end
        else if (r.op == OP_LOAD)
            work_items++;
    endtask

    task automatic random_line();
        request_t ld;
        int pick, span, dx, dy, len, n;
        ld = any_request(OP_LOAD);
        pick = $urandom_range(0, 99);
        span = pick < 70 ? 8 : (pick < 97 ? 40 : COORD_MAX);
        if ($urandom_range(0, 7) == 0)
            ld.sx = COORD_BITS'($urandom_range(0, 1) ? COORD_MAX : 0);
        if ($urandom_range(0, 7) == 0)
            ld.sy = COORD_BITS'($urandom_range(0, 1) ? COORD_MAX : 0);
        ld.ex = near(ld.sx, span);
        ld.ey = near(ld.sy, span);
        dx = int'(ld.ex) - int'(ld.sx);
        dy = int'(ld.ey) - int'(ld.sy);
        dx = dx < 0 ? -dx : dx;
        dy = dy < 0 ? -dy : dy;
        len = (dx > dy ? dx : dy) + 1;
        n = len;
        // long lines are usually cut off by the next load
        if (span == COORD_MAX && $urandom_range(0, 2) != 0)
            n = $urandom_range(1, 30);
        else if ($urandom_range(0, 9) == 0)
            n = $urandom_range(0, len);
        else if ($urandom_range(0, 9) == 0)
            n = len + int'($urandom_range(1, 3));
        run(ld);
        repeat (n) run(any_request(OP_STEP));
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // pixel side: check and random back-pressure
    always @(posedge clk)
    begin
        pixel_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.x = m_axis_tdata[COORD_BITS-1:0];
            got.y = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            got.color = m_axis_tdata[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS];
            got.last = m_axis_tlast;
            if (pixel_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel x=%0d y=%0d color=%0d last=%0d",
                         $time, got.x, got.y, got.color, got.last);
            end
            else
            begin
                want = pixel_q.pop_front();
                n_checked++;
                compare_field("pixel_x", int'(want.x), int'(got.x));
                compare_field("pixel_y", int'(want.y), int'(got.y));
                compare_field("color_out", int'(want.color), int'(got.color));
                compare_field("last_pixel", int'(want.last), int'(got.last));
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            hold_left = pause_len();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            hang_cycles = 0;
        else
        begin
            hang_cycles++;
            if (hang_cycles >= HANG_LIMIT)
            begin
                $display("%0t: no request or pixel moved for %0d cycles, %0d pixels outstanding",
                         $time, hang_cycles, pixel_q.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    row_t plan [0:23];

    initial
    begin
        pixel_t px;
        int next_mood;

        pixels_to_go = '0;
        trace_x = '0;
        trace_y = '0;
        inc_x = '0;
        inc_y = '0;
        trace_color = '0;

        // step after reset, single-point lines at both corners, a full-screen
        // diagonal replaced mid-line, and half-pixel rounding either way
        plan = '{
            '{'{OP_STEP, 0, 0, 0, 0, 0},                NO_PIXEL,    '{0, 0, 0, 0}},
            '{'{OP_LOAD, 0, 0, 0, 0, 15},               NO_PIXEL,    '{0, 0, 0, 0}},
            '{'{OP_STEP, 1023, 1023, 1023, 1023, 0},    FIXED_PIXEL, '{0, 0, 15, 1}},
            '{'{OP_STEP, 0, 0, 0, 0, 0},                NO_PIXEL,    '{0, 0, 0, 0}},
            '{'{OP_LOAD, 1023, 1023, 1023, 1023, 0},    NO_PIXEL,    '{0, 0, 0, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 15},               FIXED_PIXEL, '{1023, 1023, 0, 1}},
            '{'{OP_LOAD, 1023, 0, 0, 1023, 10},         NO_PIXEL,    '{0, 0, 0, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 0},                FIXED_PIXEL, '{1023, 0, 10, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 0},                FIXED_PIXEL, '{1022, 1, 10, 0}},
            '{'{OP_LOAD, 0, 1023, 3, 1022, 5},          NO_PIXEL,    '{0, 0, 0, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 0},                FIXED_PIXEL, '{0, 1023, 5, 0}},
            '{'{OP_STEP, 512, 512, 512, 512, 8},        BY_MODEL,    '{0, 0, 0, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 0},                BY_MODEL,    '{0, 0, 0, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 0},                FIXED_PIXEL, '{3, 1022, 5, 1}},
            '{'{OP_STEP, 0, 0, 0, 0, 0},                NO_PIXEL,    '{0, 0, 0, 0}},
            '{'{OP_LOAD, 10, 20, 12, 21, 7},            NO_PIXEL,    '{0, 0, 0, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 0},                BY_MODEL,    '{0, 0, 0, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 0},                BY_MODEL,    '{0, 0, 0, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 0},                BY_MODEL,    '{0, 0, 0, 0}},
            '{'{OP_LOAD, 12, 21, 10, 20, 9},            NO_PIXEL,    '{0, 0, 0, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 0},                BY_MODEL,    '{0, 0, 0, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 0},                BY_MODEL,    '{0, 0, 0, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 0},                BY_MODEL,    '{0, 0, 0, 0}},
            '{'{OP_STEP, 0, 0, 0, 0, 0},                NO_PIXEL,    '{0, 0, 0, 0}}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            issue(plan[i].req);
            if (rasterize(plan[i].req, px) && plan[i].verdict == BY_MODEL)
                pixel_q.push_back(px);
            if (plan[i].verdict == FIXED_PIXEL)
                pixel_q.push_back(plan[i].want);
        end

        work_items = 0;
        next_mood = 0;
        while (work_items < WORK_TARGET)
        begin
            if (work_items >= next_mood)
            begin
                quiet = $urandom_range(0, 3) == 0;
                next_mood += 150;
            end
            if ($urandom_range(0, 99) < 8)
                run(any_request($urandom_range(0, 1) ? OP_STEP : OP_LOAD));
            else
                random_line();
        end
        s_axis_tvalid <= 1'b0;
        quiet = 1'b0;

        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (pixel_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d pixels never arrived", $time, pixel_q.size());
        end
        $display("%0d lines loaded (%0d replaced mid-line, longest %0d pixels), %0d pixels checked",
                 n_lines, n_replaced, n_longest, n_checked);
        $display("%0d steps reached an idle rasterizer, random stalls on both sides", n_idle_steps);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
